// ----- hw/rtl/face_sector_nearest_neighbor_assert.svh -----
// Assertion macros for the face-sector nearest-neighbor RTL.
`ifndef FACE_SECTOR_NEAREST_NEIGHBOR_ASSERT_SVH
`define FACE_SECTOR_NEAREST_NEIGHBOR_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define FSNN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define FSNN_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/fsnn_pkg.sv -----
// Types, constants and helpers for the face-sector nearest-neighbor block.
package fsnn_pkg;

  localparam int CoordBits  = 24;
  localparam int IdBits     = 16;
  localparam int TolBits    = 10;
  localparam int Quadrants  = 4;
  localparam int Faces      = 6;
  localparam int Sectors    = Quadrants * Faces;
  localparam int SlotBits   = $clog2(Sectors);
  localparam int DiffBits   = CoordBits + 1;
  localparam int SqBits     = 2 * DiffBits;
  localparam int DistBits   = SqBits + 2;
  localparam int QueueDepth = 4;
  localparam int PtrBits    = $clog2(QueueDepth);

  typedef struct packed {
    logic signed [CoordBits-1:0] cur_x;
    logic signed [CoordBits-1:0] cur_y;
    logic signed [CoordBits-1:0] cur_z;
    logic signed [CoordBits-1:0] nbr_x;
    logic signed [CoordBits-1:0] nbr_y;
    logic signed [CoordBits-1:0] nbr_z;
    logic [IdBits-1:0]           nbr_id;
    logic                        has_neighbor;
    logic                        last_item;
  } fsnn_in_t;

  typedef struct packed {
    logic [1:0]        sign_quadrant;
    logic [2:0]        face_index;
    logic [IdBits-1:0] chosen_id;
    logic              found;
    logic              last_result;
  } fsnn_out_t;

  // One classified item on its way from the front part to the sector table.
  typedef struct packed {
    logic                nbr;
    logic [SlotBits-1:0] slot;
    logic [DistBits-1:0] sq_dist;
    logic [IdBits-1:0]   id;
    logic                last;
  } fsnn_op_t;

  function automatic logic [1:0] slot_quad(input logic [SlotBits-1:0] s);
    logic [1:0] q;
    if (s >= SlotBits'(3 * Faces)) q = 2'd3;
    else if (s >= SlotBits'(2 * Faces)) q = 2'd2;
    else if (s >= SlotBits'(Faces)) q = 2'd1;
    else q = 2'd0;
    return q;
  endfunction

  function automatic logic [2:0] slot_face(input logic [SlotBits-1:0] s);
    logic [SlotBits-1:0] base;
    base = SlotBits'(slot_quad(s)) * SlotBits'(Faces);
    return 3'(s - base);
  endfunction

endpackage

// ----- hw/rtl/fsnn_front.sv -----
// Front part: offsets, magnitudes, squares and face/quadrant classification.
module fsnn_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  fsnn_pkg::fsnn_in_t              in_data_i,
  input  logic [fsnn_pkg::TolBits-1:0]    tol_i,
  input  logic                            full_i,
  output logic                            push_o,
  output fsnn_pkg::fsnn_op_t              op_o
);
  import fsnn_pkg::*;

  localparam logic [1:0] AxisX = 2'd0;
  localparam logic [1:0] AxisY = 2'd1;
  localparam logic [1:0] AxisZ = 2'd2;

  logic signed [DiffBits-1:0] diff_c [3];
  logic [DiffBits-1:0]        mag_c  [3];

  logic                       s1_v_q, s1_v_d;
  logic signed [DiffBits-1:0] s1_diff_q [3];
  logic [DiffBits-1:0]        s1_mag_q  [3];
  logic [IdBits-1:0]          s1_id_q;
  logic                       s1_nbr_q;
  logic                       s1_last_q;

  logic                       s2_v_q, s2_v_d;
  logic [SqBits-1:0]          s2_sq_q [3];
  logic                       s2_hit_q;
  logic [SlotBits-1:0]        s2_slot_q;
  logic [IdBits-1:0]          s2_id_q;
  logic                       s2_last_q;

  logic                       s1_free, s2_free, s2_need;
  logic [DiffBits-1:0]        tol_ext;
  logic [2:0]                 cand, pos, neg;
  logic [1:0]                 axis, quad;
  logic                       hit;
  logic [2:0]                 face;
  logic [SlotBits-1:0]        slot;

  assign diff_c[0] = DiffBits'(in_data_i.nbr_x) - DiffBits'(in_data_i.cur_x);
  assign diff_c[1] = DiffBits'(in_data_i.nbr_y) - DiffBits'(in_data_i.cur_y);
  assign diff_c[2] = DiffBits'(in_data_i.nbr_z) - DiffBits'(in_data_i.cur_z);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag_c[k] = diff_c[k][DiffBits-1] ? DiffBits'(-diff_c[k]) : DiffBits'(diff_c[k]);
    end
  end

  // Handshake: a stage advances when the one after it can take its contents.
  assign s2_need = s2_hit_q || s2_last_q;
  assign push_o  = s2_v_q && s2_need && !full_i;
  assign s2_free = !s2_v_q || !s2_need || !full_i;
  assign s1_free = !s1_v_q || s2_free;
  assign in_stall_o = !s1_free;

  assign s1_v_d = s1_free ? in_valid_i : s1_v_q;
  assign s2_v_d = s2_free ? s1_v_q : s2_v_q;

  // Classification of the stage 1 offsets.
  assign tol_ext = DiffBits'(tol_i);
  assign cand[0] = (s1_mag_q[0] > tol_ext) && (s1_mag_q[0] >= s1_mag_q[1])
                   && (s1_mag_q[0] >= s1_mag_q[2]);
  assign cand[1] = (s1_mag_q[1] > tol_ext) && (s1_mag_q[1] >= s1_mag_q[2])
                   && (s1_mag_q[1] >= s1_mag_q[0]);
  assign cand[2] = (s1_mag_q[2] > tol_ext) && (s1_mag_q[2] >= s1_mag_q[0])
                   && (s1_mag_q[2] >= s1_mag_q[1]);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      neg[k] = s1_diff_q[k][DiffBits-1];
      pos[k] = !neg[k] && (|s1_diff_q[k]);
    end
  end

  always_comb begin
    if (cand[0]) axis = AxisX;
    else if (cand[1]) axis = AxisY;
    else axis = AxisZ;
  end

  assign hit = s1_nbr_q && (|cand);

  always_comb begin
    unique case (axis)
      AxisX:   begin quad = {pos[1], pos[2]}; face = {axis, !neg[0]}; end
      AxisY:   begin quad = {pos[0], pos[2]}; face = {axis, !neg[1]}; end
      default: begin quad = {pos[0], pos[1]}; face = {axis, !neg[2]}; end
    endcase
  end

  assign slot = SlotBits'({quad, 2'b00}) + SlotBits'({quad, 1'b0}) + SlotBits'(face);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
      s2_v_q <= s2_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_free && in_valid_i) begin
      for (int k = 0; k < 3; k++) begin
        s1_diff_q[k] <= diff_c[k];
        s1_mag_q[k]  <= mag_c[k];
      end
      s1_id_q   <= in_data_i.nbr_id;
      s1_nbr_q  <= in_data_i.has_neighbor;
      s1_last_q <= in_data_i.last_item;
    end
    if (s2_free && s1_v_q) begin
      for (int k = 0; k < 3; k++) begin
        s2_sq_q[k] <= s1_mag_q[k] * s1_mag_q[k];
      end
      s2_hit_q  <= hit;
      s2_slot_q <= slot;
      s2_id_q   <= s1_id_q;
      s2_last_q <= s1_last_q;
    end
  end

  always_comb begin
    op_o.nbr     = s2_hit_q;
    op_o.slot    = s2_slot_q;
    op_o.sq_dist = DistBits'(s2_sq_q[0]) + DistBits'(s2_sq_q[1]) + DistBits'(s2_sq_q[2]);
    op_o.id      = s2_id_q;
    op_o.last    = s2_last_q;
  end

endmodule

// ----- hw/rtl/fsnn_queue.sv -----
// Short queue of classified items between the front part and the sector table.
module fsnn_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  fsnn_pkg::fsnn_op_t  op_i,
  output logic                full_o,
  input  logic                pop_i,
  output fsnn_pkg::fsnn_op_t  op_o,
  output logic                empty_o
);
  import fsnn_pkg::*;

  fsnn_op_t           mem_q [QueueDepth];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrBits:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (PtrBits+1)'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign op_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + PtrBits'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + PtrBits'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + (PtrBits+1)'(1);
    else if (pop_i && !push_i) cnt_d = cnt_q - (PtrBits+1)'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= op_i;
  end

endmodule

// ----- hw/rtl/fsnn_back.sv -----
// Back part: per-sector nearest-neighbor table and result drain.
module fsnn_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fsnn_pkg::fsnn_op_t  op_i,
  input  logic                empty_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output fsnn_pkg::fsnn_out_t out_data_o
);
  import fsnn_pkg::*;

  `include "face_sector_nearest_neighbor_assert.svh"

  typedef enum logic {StRun, StDrain} state_e;

  state_e              state_q, state_d;
  logic [Sectors-1:0]  used_q, used_d;
  logic [Sectors-1:0]  pend_q, pend_d;
  logic                out_v_q, out_v_d;
  fsnn_out_t           out_q, out_d;

  logic [DistBits-1:0] dist_q [Sectors];
  logic [IdBits-1:0]   id_q   [Sectors];

  logic                upd, out_free;
  logic [Sectors-1:0]  used_upd, pend_rest;
  logic [SlotBits-1:0] idx;

  assign pop_o    = (state_q == StRun) && !empty_i;
  assign upd      = pop_o && op_i.nbr
                    && (!used_q[op_i.slot] || (op_i.sq_dist < dist_q[op_i.slot]));
  assign used_upd = used_q | (upd ? (Sectors'(1) << op_i.slot) : '0);
  assign out_free = !out_v_q || !out_stall_i;

  // Lowest pending sector goes out first; clear it from the rest.
  always_comb begin
    idx = '0;
    for (int i = Sectors - 1; i >= 0; i--) begin
      if (pend_q[i]) idx = SlotBits'(i);
    end
  end
  assign pend_rest = pend_q & (pend_q - Sectors'(1));

  always_comb begin
    state_d = state_q;
    used_d  = used_q;
    pend_d  = pend_q;
    out_v_d = out_v_q && out_stall_i;
    out_d   = out_q;
    unique case (state_q)
      StRun: begin
        if (pop_o) begin
          used_d = used_upd;
          if (op_i.last) begin
            pend_d  = used_upd;
            used_d  = '0;
            state_d = StDrain;
          end
        end
      end
      StDrain: begin
        if (out_free) begin
          out_v_d = 1'b1;
          if (pend_q == '0) begin
            out_d             = '0;
            out_d.last_result = 1'b1;
            state_d           = StRun;
          end else begin
            out_d.sign_quadrant = slot_quad(idx);
            out_d.face_index    = slot_face(idx);
            out_d.chosen_id     = id_q[idx];
            out_d.found         = 1'b1;
            out_d.last_result   = (pend_rest == '0);
            pend_d              = pend_rest;
            if (pend_rest == '0) state_d = StRun;
          end
        end
      end
      default: state_d = StRun;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StRun;
      used_q  <= '0;
      pend_q  <= '0;
      out_v_q <= 1'b0;
      out_q   <= '0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      pend_q  <= pend_d;
      out_v_q <= out_v_d;
      out_q   <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd) begin
      dist_q[op_i.slot] <= op_i.sq_dist;
      id_q[op_i.slot]   <= op_i.id;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  `FSNN_ASSERT_NXT(a_last_enters_drain, pop_o && op_i.last, state_q == StDrain, "missed drain")
  `FSNN_ASSERT_NXT(a_last_clears_table, pop_o && op_i.last, used_q == '0, "table not cleared")
  `FSNN_ASSERT_NXT(a_pend_shrinks, state_q == StDrain, ~|(pend_q & ~$past(pend_q)), "pend grew")
  `FSNN_ASSERT_IMP(a_empty_is_last, out_v_q && !out_q.found, out_q.last_result, "empty not last")

endmodule

// ----- hw/rtl/face_sector_nearest_neighbor.sv -----
// Path: stage 1, stage 2, queue, drain state, output register. Throughput: one item per
// cycle while the queue has room, set by the two-stage front pipeline and one table
// update. A last item drains one result per unstalled cycle from the sector table (one per
// occupied sector, at least one); items wait in the 4-entry queue until the drain ends.
// Reset: pipeline, queue, occupied-sector bits and output valid clear at once; the
// tolerance register resets to 0. Sector distances and ids hold no reset value.
module face_sector_nearest_neighbor (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fsnn_pkg::TolBits-1:0]    cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  fsnn_pkg::fsnn_in_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output fsnn_pkg::fsnn_out_t             out_data_o
);
  import fsnn_pkg::*;

  logic [TolBits-1:0] tol_q;
  logic               push, pop, full, empty;
  fsnn_op_t           push_op, head_op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  fsnn_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .tol_i      (tol_q),
    .full_i     (full),
    .push_o     (push),
    .op_o       (push_op)
  );

  fsnn_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (push_op),
    .full_o  (full),
    .pop_i   (pop),
    .op_o    (head_op),
    .empty_o (empty)
  );

  fsnn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (head_op),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- dv/face_sector_nearest_neighbor_test.sv -----
// Self-checking testbench for the face-sector nearest-neighbor selector.
module face_sector_nearest_neighbor_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fsnn_pkg::*;

  localparam int CycleLimit = 2000000;
  localparam int ItemTarget = 420;

  typedef struct {
    bit                 wr_tol;
    logic [TolBits-1:0] tol;
    fsnn_in_t           item;
    bit                 typed;
    fsnn_out_t          want;
  } row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [TolBits-1:0] cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  fsnn_in_t           in_data_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  fsnn_out_t          out_data_o;

  // Sector table as the block should hold it.
  logic [TolBits-1:0]  tolerance = '0;
  logic                occupied [Sectors];
  logic [IdBits-1:0]   best_id [Sectors];
  logic [DistBits-1:0] best_dist [Sectors];

  fsnn_out_t sector_results_q [$];
  int        errors = 0;
  int        cycles = 0;
  int        items_sent = 0;
  int        stall_left = 0;
  bit        quiet = 1'b0;

  face_sector_nearest_neighbor DUT (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_stall_o,
    .in_data_i,
    .out_valid_o,
    .out_stall_i,
    .out_data_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Add one item to the table; a closing item emits occupied sectors, else one empty result.
  function automatic void nearest_per_sector(input fsnn_in_t it, ref fsnn_out_t res[$]);
    logic signed [DiffBits-1:0] diff [3];
    logic [DiffBits-1:0]        mag [3];
    logic [DistBits-1:0]        sq_dist;
    logic [1:0]                 quad;
    logic [2:0]                 face;
    fsnn_out_t                  r;
    int                         axis;
    int                         slot;
    int                         k;
    if (it.has_neighbor) begin
      diff[0] = $signed(it.nbr_x) - $signed(it.cur_x);
      diff[1] = $signed(it.nbr_y) - $signed(it.cur_y);
      diff[2] = $signed(it.nbr_z) - $signed(it.cur_z);
      sq_dist = '0;
      axis = -1;
      for (k = 0; k < 3; k++) begin
        mag[k] = diff[k][DiffBits-1] ? -diff[k] : diff[k];
        sq_dist = sq_dist + mag[k] * mag[k];
      end
      for (k = 0; k < 3; k++) begin
        if (axis < 0 && mag[k] > tolerance && mag[k] >= mag[(k + 1) % 3] &&
            mag[k] >= mag[(k + 2) % 3]) axis = k;
      end
      if (axis >= 0) begin
        quad = '0;
        for (k = 0; k < 3; k++) begin
          if (k != axis) quad = {quad[0], (!diff[k][DiffBits-1] && diff[k] != 0)};
        end
        face = 3'(2 * axis + (diff[axis][DiffBits-1] ? 0 : 1));
        slot = int'(quad) * Faces + int'(face);
        // The first neighbor at a given distance keeps the sector.
        if (!occupied[slot] || sq_dist < best_dist[slot]) begin
          occupied[slot] = 1'b1;
          best_dist[slot] = sq_dist;
          best_id[slot] = it.nbr_id;
        end
      end
    end
    if (it.last_item) begin
      for (k = 0; k < Sectors; k++) begin
        if (occupied[k]) begin
          r.sign_quadrant = 2'(k / Faces);
          r.face_index = 3'(k % Faces);
          r.chosen_id = best_id[k];
          r.found = 1'b1;
          r.last_result = 1'b0;
          res = {res, r};
        end
        occupied[k] = 1'b0;
      end
      if (res.size() == 0) begin
        r = '0;
        r.last_result = 1'b1;
        res = {res, r};
      end else res[res.size() - 1].last_result = 1'b1;
    end
  endfunction

  function automatic fsnn_in_t mk_item(input int cx, input int cy, input int cz, input int nx,
                                       input int ny, input int nz, input int id, input bit hn,
                                       input bit lst);
    fsnn_in_t it;
    it.cur_x = CoordBits'(cx);
    it.cur_y = CoordBits'(cy);
    it.cur_z = CoordBits'(cz);
    it.nbr_x = CoordBits'(nx);
    it.nbr_y = CoordBits'(ny);
    it.nbr_z = CoordBits'(nz);
    it.nbr_id = IdBits'(id);
    it.has_neighbor = hn;
    it.last_item = lst;
    return it;
  endfunction

  function automatic fsnn_out_t one_result(input int q, input int f, input int id, input bit fnd);
    return '{2'(q), 3'(f), IdBits'(id), fnd, 1'b1};
  endfunction

  function automatic fsnn_in_t noise_item();
    fsnn_in_t it;
    it.cur_x = CoordBits'($urandom);
    it.cur_y = CoordBits'($urandom);
    it.cur_z = CoordBits'($urandom);
    it.nbr_x = CoordBits'($urandom);
    it.nbr_y = CoordBits'($urandom);
    it.nbr_z = CoordBits'($urandom);
    it.nbr_id = IdBits'($urandom);
    it.has_neighbor = 1'($urandom_range(0, 1));
    it.last_item = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // Per-axis offset: 0 near the tolerance, 1 medium, 2 large, else anywhere (wraps).
  function automatic int draw_offset(input int shape);
    case (shape)
      0: return int'($urandom_range(0, 2 * int'(tolerance) + 6)) - int'(tolerance) - 3;
      1: return int'($urandom_range(0, 8191)) - 4096;
      2: return int'($urandom_range(0, 8388607)) - 4194304;
      default: return int'($urandom_range(0, 16777215)) - 8388608;
    endcase
  endfunction

  task automatic send_item(input fsnn_in_t it, input bit typed, input fsnn_out_t want);
    fsnn_out_t made [$];
    int        gap;
    gap = quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    nearest_per_sector(it, made);
    if (typed) sector_results_q = {sector_results_q, want};
    else foreach (made[i]) sector_results_q = {sector_results_q, made[i]};
  endtask

  // Drop valid, wait out every expected result, then let the front pipeline empty.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sector_results_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_tolerance(input logic [TolBits-1:0] value);
    settle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tolerance = value;
  endtask

  task automatic run_query();
    fsnn_in_t it;
    int       cur [3];
    int       off [3];
    int       count;
    int       shape;
    int       m;
    int       n;
    int       a;
    bit       close_apart;
    quiet = ($urandom_range(0, 4) == 0);
    // Stray item with random flags breaks up the query structure.
    if ($urandom_range(0, 6) == 0) begin
      it = noise_item();
      send_item(it, 1'b0, '0);
      return;
    end
    count = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 70) : $urandom_range(1, 12);
    close_apart = ($urandom_range(0, 3) == 0);
    for (a = 0; a < 3; a++) begin
      cur[a] = $urandom_range(0, 1) ? int'($urandom_range(0, 8191)) - 4096 : draw_offset(3);
      off[a] = 0;
    end
    for (n = 0; n < count; n++) begin
      shape = $urandom_range(0, 5);
      if (shape == 4) begin
        // Equal magnitudes on several axes exercise the axis priority.
        m = $urandom_range(0, 3000);
        for (a = 0; a < 3; a++)
          off[a] = ($urandom_range(0, 2) == 0) ? 0 : ($urandom_range(0, 1) ? m : -m);
      end else if (shape != 5 || n == 0) begin
        for (a = 0; a < 3; a++) off[a] = draw_offset(shape == 5 ? 1 : shape);
      end
      // Shape 5 repeats the previous offset with a new id: a distance tie.
      it = noise_item();
      it.cur_x = CoordBits'(cur[0]);
      it.cur_y = CoordBits'(cur[1]);
      it.cur_z = CoordBits'(cur[2]);
      it.nbr_x = CoordBits'(cur[0] + off[0]);
      it.nbr_y = CoordBits'(cur[1] + off[1]);
      it.nbr_z = CoordBits'(cur[2] + off[2]);
      it.has_neighbor = ($urandom_range(0, 11) != 0);
      it.last_item = (n == count - 1) && !close_apart;
      send_item(it, 1'b0, '0);
    end
    if (close_apart) begin
      it = noise_item();
      it.has_neighbor = ($urandom_range(0, 3) == 0);
      it.last_item = 1'b1;
      send_item(it, 1'b0, '0);
    end
  endtask

  always @(posedge clk_i) begin : receiver
    if (out_stall_i) begin
      stall_left = stall_left - 1;
      if (stall_left <= 0) out_stall_i <= 1'b0;
    end else if (rst_ni && out_valid_o) begin
      stall_left = quiet ? 0 : $urandom_range(0, 19);
      if (stall_left > 0) out_stall_i <= 1'b1;
    end else if (!quiet && $urandom_range(0, 15) == 0) begin
      stall_left = $urandom_range(1, 19);
      out_stall_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : result_check
    fsnn_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (sector_results_q.size() == 0) begin
        $error("result transfer with none expected: %p", out_data_o);
        errors++;
      end else begin
        want = sector_results_q.pop_front();
        if (out_data_o.sign_quadrant !== want.sign_quadrant) begin
          $error("sign_quadrant: expected %0d, got %0d", want.sign_quadrant,
                 out_data_o.sign_quadrant);
          errors++;
        end
        if (out_data_o.face_index !== want.face_index) begin
          $error("face_index: expected %0d, got %0d", want.face_index, out_data_o.face_index);
          errors++;
        end
        if (out_data_o.chosen_id !== want.chosen_id) begin
          $error("chosen_id: expected 0x%04h, got 0x%04h", want.chosen_id,
                 out_data_o.chosen_id);
          errors++;
        end
        if (out_data_o.found !== want.found) begin
          $error("found: expected %0b, got %0b", want.found, out_data_o.found);
          errors++;
        end
        if (out_data_o.last_result !== want.last_result) begin
          $error("last_result: expected %0b, got %0b", want.last_result,
                 out_data_o.last_result);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    row_t directed_rows [18];
    int   phase;
    foreach (occupied[s]) occupied[s] = 1'b0;
    directed_rows = '{
      '{1'b0, 10'd0, mk_item(-1, -1, -1, -1, -1, -1, 'hFFFF, 1'b0, 1'b1),
        1'b1, one_result(0, 0, 0, 1'b0)},
      '{1'b0, 10'd0, mk_item(100, 200, 300, 1100, 200, 300, 'hFFFF, 1'b1, 1'b1),
        1'b1, one_result(0, 1, 'hFFFF, 1'b1)},
      '{1'b0, 10'd0, mk_item(-8388608, -8388608, 8388607, 8388607, -8388608, 8388607, 0,
                             1'b1, 1'b1),
        1'b1, one_result(0, 1, 0, 1'b1)},
      '{1'b0, 10'd0, mk_item(8388607, 0, 0, -8388608, 5, 0, 'h8001, 1'b1, 1'b1),
        1'b1, one_result(2, 0, 'h8001, 1'b1)},
      // Zero offset: every axis is parallel.
      '{1'b0, 10'd0, mk_item(-8388608, 8388607, 0, -8388608, 8388607, 0, 'h7777, 1'b1, 1'b1),
        1'b1, one_result(0, 0, 0, 1'b0)},
      '{1'b0, 10'd0, mk_item(10, 20, 30, 17, 13, 37, 1, 1'b1, 1'b0), 1'b0, '0},
      '{1'b0, 10'd0, mk_item(10, 20, 30, 17, 13, 37, 2, 1'b1, 1'b0), 1'b0, '0},
      '{1'b0, 10'd0, mk_item(10, 20, 30, 7, 17, 27, 3, 1'b1, 1'b0), 1'b0, '0},
      '{1'b0, 10'd0, mk_item(10, 20, 30, 10, 29, 21, 4, 1'b1, 1'b0), 1'b0, '0},
      '{1'b0, 10'd0, mk_item(10, 20, 30, 10, 20, 26, 5, 1'b1, 1'b0), 1'b0, '0},
      '{1'b0, 10'd0, mk_item(10, 20, 30, 12, 15, 31, 6, 1'b1, 1'b0), 1'b0, '0},
      '{1'b0, 10'd0, mk_item(10, 20, 30, 11, 21, 39, 7, 1'b1, 1'b0), 1'b0, '0},
      '{1'b0, 10'd0, mk_item(8388607, -8388608, -1, -8388608, 8388607, 1, 'h5A5A, 1'b0, 1'b0),
        1'b0, '0},
      '{1'b0, 10'd0, mk_item(10, 20, 30, 12, 18, 32, 8, 1'b1, 1'b0), 1'b0, '0},
      '{1'b0, 10'd0, mk_item(10, 20, 30, 9, 24, 30, 9, 1'b1, 1'b1), 1'b0, '0},
      // Offsets at the tolerance are still parallel.
      '{1'b1, 10'd1023, mk_item(0, 0, 0, 1023, 0, 0, 'h00AA, 1'b1, 1'b1),
        1'b1, one_result(0, 0, 0, 1'b0)},
      '{1'b0, 10'd0, mk_item(5000, -200, 77, 3976, 823, 77, 'h1234, 1'b1, 1'b1),
        1'b1, one_result(2, 0, 'h1234, 1'b1)},
      '{1'b0, 10'd0, mk_item(-1, 2, -3, 1022, -1021, 1020, 'h4321, 1'b1, 1'b1),
        1'b1, one_result(0, 0, 0, 1'b0)}
    };
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].wr_tol) write_tolerance(directed_rows[i].tol);
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    end

    write_tolerance('0);
    phase = 0;
    while (items_sent < ItemTarget) begin
      if (items_sent >= 90 * (phase + 1)) begin
        phase++;
        case (phase)
          1: write_tolerance(10'd1023);
          2: write_tolerance(TolBits'($urandom_range(1, 1022)));
          3: write_tolerance(10'd3);
          default: write_tolerance(TolBits'($urandom_range(0, 63)));
        endcase
      end
      run_query();
    end
    settle();

    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
